// File: src/tod_pkg.sv
// tilt orientation detector: shared types, codes and the cordic angle table
`timescale 1ns / 1ps

package tod_pkg;

    // command codes carried in the input tuser
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_SAMPLE = 2'd0;
    localparam t_cmd CMD_STOP   = 2'd1;
    localparam t_cmd CMD_LEAVE  = 2'd2;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_FLAT    = 3'd0;
    localparam t_status ST_HYST    = 3'd1;
    localparam t_status ST_BLOCKED = 3'd2;
    localparam t_status ST_COUNT   = 3'd3;
    localparam t_status ST_SWITCH  = 3'd4;
    localparam t_status ST_CMD     = 3'd5;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_FLAT_THR  = 3'd0;
    localparam t_cfg_addr CFG_HYST      = 3'd1;
    localparam t_cfg_addr CFG_CONFIRM   = 3'd2;
    localparam t_cfg_addr CFG_ALLOWED   = 3'd3;
    localparam t_cfg_addr CFG_INVERT_X  = 3'd4;

    // register widths and reset values
    localparam int FLAT_W    = 15;
    localparam int HYST_W    = 11;
    localparam int CONFIRM_W = 3;
    localparam logic [FLAT_W-1:0]    FLAT_RST    = 15'd6554;
    localparam logic [HYST_W-1:0]    HYST_RST    = 11'd228;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RST = 3'd2;
    localparam logic [3:0]           ALLOWED_RST = 4'd5;

    // orientation indexes, with one extra code for none or unknown
    typedef logic [2:0] t_orient;
    localparam t_orient ORIENT_NORMAL = 3'd0;
    localparam t_orient ORIENT_NONE   = 3'd4;
    localparam logic [2:0] MATCH_MAX  = 3'd7;

    // output word layout
    localparam int OUT_W = 8;

    // cordic: fixed step count, angle accumulated in 2^-24 turn
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int TURN_BITS    = 24;

    function automatic logic [TURN_BITS-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic [TURN_BITS-1:0] res;
        case (idx)
            4'd0:    res = 24'd2097152;
            4'd1:    res = 24'd1238021;
            4'd2:    res = 24'd654136;
            4'd3:    res = 24'd332050;
            4'd4:    res = 24'd166669;
            4'd5:    res = 24'd83416;
            4'd6:    res = 24'd41718;
            4'd7:    res = 24'd20860;
            4'd8:    res = 24'd10430;
            4'd9:    res = 24'd5215;
            4'd10:   res = 24'd2608;
            4'd11:   res = 24'd1304;
            4'd12:   res = 24'd652;
            4'd13:   res = 24'd326;
            4'd14:   res = 24'd163;
            4'd15:   res = 24'd81;
            default: res = 24'd0;
        endcase
        return res;
    endfunction

endpackage

// File: src/tilt_orientation_detector.sv
// tilt orientation detector: flat check, cordic up angle, hysteresis and confirm logic
`timescale 1ns / 1ps
// a sample word runs accept, the x, y and threshold squares, flat compare, cordic rotations
//   and the decision; a flat sample skips the rotations, a command word goes to the decision
// throughput: one word at a time, set by the 16-step cordic loop on one shared add/shift unit
// the result sits in an output register; the next word is accepted while it waits
// reset (synchronous, active low) restores the control and configuration registers to their defaults,
//   orientation normal, no pending candidate, applied orientation unknown

module tilt_orientation_detector #(
    parameter int SAMPLE_BITS = 16,
    parameter int ANGLE_BITS  = 12
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write port
    input  logic                                     i_cfg_wen,
    input  logic [tod_pkg::CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [tod_pkg::CFG_DATA_W-1:0]           i_cfg_wdata,
    // input words
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // accel_x, accel_y (low bits up), zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // cmd
    input  logic [1:0]                               s_axis_tuser,
    // result words
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // orientation[1:0], apply_request[2], status[5:3], zeros above
    output logic [tod_pkg::OUT_W-1:0]                m_axis_tdata
);
    import tod_pkg::*;

    // multiplier operand width: holds a negated sample and the threshold
    localparam int XW   = SAMPLE_BITS + 1;
    localparam int MW   = (XW > FLAT_W + 1) ? XW : FLAT_W + 1;
    localparam int MAGW = (2*SAMPLE_BITS > 2*FLAT_W) ? 2*SAMPLE_BITS : 2*FLAT_W;
    // cordic vector width: cordic gain and the diagonal need two more bits
    localparam int CW   = SAMPLE_BITS + 3;
    localparam int HLW  = ((ANGLE_BITS > HYST_W) ? ANGLE_BITS : HYST_W) + 1;
    localparam logic [TURN_BITS-1:0] HALF_TURN = TURN_BITS'(1) << (TURN_BITS - 1);
    localparam logic [TURN_BITS-1:0] ROUND_HALF = TURN_BITS'(1) << (TURN_BITS - 1 - ANGLE_BITS);
    localparam logic [HLW-1:0] EIGHTH = HLW'(1) << (ANGLE_BITS - 3);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQX  = 7'b0000010,
        S_SQY  = 7'b0000100,
        S_SQT  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_ROT  = 7'b0100000,
        S_DEC  = 7'b1000000
    } t_state;

    // configuration registers
    logic [FLAT_W-1:0]    r_flat_thr;
    logic [HYST_W-1:0]    r_hyst;
    logic [CONFIRM_W-1:0] r_confirm;
    logic [3:0]           r_allowed;
    logic                 r_invert_x;

    // control and orientation state
    t_state  r_state, n_state;
    t_orient r_cur, n_cur;
    t_orient r_pend, n_pend;
    logic [2:0] r_match, n_match;
    t_orient r_applied, n_applied;

    // word in flight
    t_cmd                 r_cmd;
    logic signed [XW-1:0] r_x, r_y;
    logic [MAGW-1:0]      r_mag, r_thr2;
    logic                 r_flat, r_zero;

    // cordic datapath
    logic signed [CW-1:0] r_u, r_v;
    logic [TURN_BITS-1:0] r_acc;
    logic [STEP_W-1:0]    r_iter;

    // output register
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_word;

    logic                         l_in_acc, l_dec_go;
    logic signed [XW-1:0]         l_in_x, l_in_y;
    logic signed [MW-1:0]         l_mul_a, l_mul_b;
    logic signed [2*MW-1:0]       l_prod;
    logic [MAGW-1:0]              l_prod_mag;
    logic signed [CW-1:0]         l_du, l_dv;
    logic                         l_v_pos;
    logic [TURN_BITS-1:0]         l_round;
    logic [ANGLE_BITS-1:0]        l_ang;
    logic [ANGLE_BITS-1:0]        l_dist [4];
    logic [ANGLE_BITS-1:0]        l_dist_cur;
    logic [HLW-1:0]               l_limit;
    logic [1:0]                   l_best;
    logic [2:0]                   l_inc;
    logic                         l_apply;
    t_status                      l_status;

    // centre angle of an orientation: 0, 3/4, 1/2, 1/4 turn
    function automatic logic [ANGLE_BITS-1:0] centre(input logic [1:0] idx);
        logic [1:0] q;
        case (idx)
            2'd0:    q = 2'd0;
            2'd1:    q = 2'd3;
            2'd2:    q = 2'd2;
            2'd3:    q = 2'd1;
            default: q = 2'd0;
        endcase
        return {q, {(ANGLE_BITS-2){1'b0}}};
    endfunction

    // wrapped angular distance folded into half a turn
    function automatic logic [ANGLE_BITS-1:0] ang_dist(input logic [ANGLE_BITS-1:0] a,
                                                       input logic [ANGLE_BITS-1:0] b);
        logic [ANGLE_BITS-1:0] d;
        d = a - b;
        if (d > (ANGLE_BITS'(1) << (ANGLE_BITS - 1))) begin
            d = ANGLE_BITS'(0) - d;
        end
        return d;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign l_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    // decision waits only if the previous result is still held
    assign l_dec_go      = (r_state == S_DEC) && (!r_out_valid || m_axis_tready);

    // sample unpack, x negated at full width so the most negative value does not wrap
    always_comb begin
        l_in_x = XW'(signed'(s_axis_tdata[SAMPLE_BITS-1:0]));
        l_in_y = XW'(signed'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
        if (r_invert_x) begin
            l_in_x = -l_in_x;
        end
    end

    // shared multiplier: x squared, y squared, then threshold squared
    always_comb begin
        case (r_state)
            S_SQX: begin
                l_mul_a = MW'(r_x);
                l_mul_b = MW'(r_x);
            end
            S_SQY: begin
                l_mul_a = MW'(r_y);
                l_mul_b = MW'(r_y);
            end
            default: begin
                l_mul_a = MW'(signed'({1'b0, r_flat_thr}));
                l_mul_b = MW'(signed'({1'b0, r_flat_thr}));
            end
        endcase
    end
    assign l_prod     = l_mul_a * l_mul_b;
    assign l_prod_mag = l_prod[MAGW-1:0];

    // one cordic rotation toward v = 0
    assign l_du    = r_v >>> r_iter;
    assign l_dv    = r_u >>> r_iter;
    assign l_v_pos = !r_v[CW-1] && (r_v != '0);

    // angle rounded half up to the output resolution, wrapped to one turn
    assign l_round = r_acc + ROUND_HALF;
    assign l_ang   = r_zero ? '0 : l_round[TURN_BITS-1 -: ANGLE_BITS];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l_dist[i] = ang_dist(l_ang, centre(2'(i)));
        end
        l_dist_cur = l_dist[r_cur[1:0]];
        l_limit    = EIGHTH + HLW'(r_hyst);
        // nearest centre, ties go to the lower index
        l_best = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (l_dist[i] < l_dist[l_best]) begin
                l_best = 2'(i);
            end
        end
        l_inc = (r_match < MATCH_MAX) ? r_match + 3'd1 : r_match;
    end

    // orientation update on the decision step
    always_comb begin
        n_cur     = r_cur;
        n_pend    = r_pend;
        n_match   = r_match;
        n_applied = r_applied;
        l_apply   = 1'b0;
        l_status  = ST_CMD;
        case (r_cmd)
            CMD_STOP, CMD_LEAVE: begin
                if (r_cmd == CMD_LEAVE) begin
                    n_cur = ORIENT_NORMAL;
                    if (r_applied != ORIENT_NORMAL) begin
                        n_applied = ORIENT_NORMAL;
                        l_apply   = 1'b1;
                    end
                end
                n_match = '0;
                n_pend  = ORIENT_NONE;
            end
            CMD_SAMPLE: begin
                if (r_flat) begin
                    n_match  = '0;
                    l_status = ST_FLAT;
                end else if (HLW'(l_dist_cur) <= l_limit) begin
                    n_match  = '0;
                    l_status = ST_HYST;
                end else if (!r_allowed[l_best]) begin
                    n_match  = '0;
                    l_status = ST_BLOCKED;
                end else if ({1'b0, l_best} != r_pend) begin
                    n_pend   = {1'b0, l_best};
                    n_match  = 3'd1;
                    l_status = ST_COUNT;
                end else if (l_inc >= r_confirm) begin
                    n_cur    = {1'b0, l_best};
                    n_match  = '0;
                    l_status = ST_SWITCH;
                    if (r_applied != {1'b0, l_best}) begin
                        n_applied = {1'b0, l_best};
                        l_apply   = 1'b1;
                    end
                end else begin
                    n_match  = l_inc;
                    l_status = ST_COUNT;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (l_in_acc) begin
                    n_state = (s_axis_tuser == CMD_SAMPLE) ? S_SQX : S_DEC;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_SQT;
            S_SQT: n_state = S_CHK;
            S_CHK: n_state = (r_mag < r_thr2) ? S_DEC : S_ROT;
            S_ROT: begin
                if (r_iter == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (l_dec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= ORIENT_NORMAL;
            r_pend      <= ORIENT_NONE;
            r_match     <= '0;
            r_applied   <= ORIENT_NONE;
            r_out_valid <= 1'b0;
            r_flat_thr  <= FLAT_RST;
            r_hyst      <= HYST_RST;
            r_confirm   <= CONFIRM_RST;
            r_allowed   <= ALLOWED_RST;
            r_invert_x  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (l_dec_go) begin
                r_cur       <= n_cur;
                r_pend      <= n_pend;
                r_match     <= n_match;
                r_applied   <= n_applied;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    CFG_FLAT_THR: r_flat_thr <= i_cfg_wdata[FLAT_W-1:0];
                    CFG_HYST:     r_hyst     <= i_cfg_wdata[HYST_W-1:0];
                    CFG_CONFIRM:  r_confirm  <= i_cfg_wdata[CONFIRM_W-1:0];
                    CFG_ALLOWED:  r_allowed  <= i_cfg_wdata[3:0];
                    CFG_INVERT_X: r_invert_x <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= t_cmd'(s_axis_tuser);
                r_x    <= l_in_x;
                r_y    <= l_in_y;
                r_flat <= 1'b0;
            end
            S_SQX: r_mag  <= l_prod_mag;
            S_SQY: r_mag  <= r_mag + l_prod_mag;
            S_SQT: r_thr2 <= l_prod_mag;
            S_CHK: begin
                r_flat <= (r_mag < r_thr2);
                r_zero <= (r_x == '0) && (r_y == '0);
                r_iter <= '0;
                // fold the lower half plane up by half a turn
                if (r_y[XW-1]) begin
                    r_u   <= -CW'(r_y);
                    r_v   <= -CW'(r_x);
                    r_acc <= HALF_TURN;
                end else begin
                    r_u   <= CW'(r_y);
                    r_v   <= CW'(r_x);
                    r_acc <= '0;
                end
            end
            S_ROT: begin
                r_iter <= r_iter + STEP_W'(1);
                if (l_v_pos) begin
                    r_u   <= r_u + l_du;
                    r_v   <= r_v - l_dv;
                    r_acc <= r_acc + atan_step(r_iter);
                end else begin
                    r_u   <= r_u - l_du;
                    r_v   <= r_v + l_dv;
                    r_acc <= r_acc - atan_step(r_iter);
                end
            end
            default: begin
            end
        endcase
        if (l_dec_go) begin
            r_out_word <= OUT_W'({l_status, l_apply, n_cur[1:0]});
        end
    end

    // no match count without a pending candidate
    a_match_needs_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == ORIENT_NONE) |-> (r_match == 3'd0))
        else $error("match count set with no pending candidate");

    // an apply request only comes from a switch or a command
    a_apply_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word[2]) |->
            (r_out_word[5:3] == ST_SWITCH || r_out_word[5:3] == ST_CMD))
        else $error("apply request with unexpected status");

    // a new result appears only from the decision step
    a_result_from_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DEC))
        else $error("result raised outside the decision step");

    // a held result is not overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_out_word))
        else $error("pending result changed while stalled");

endmodule
